// File: design/edrs_pkg.sv
package edrs_pkg;

    // default sizing of the request list
    localparam int EDRS_QUEUE_DEPTH = 64;
    localparam int EDRS_TRACK_BITS  = 16;

    // fixed port widths
    localparam int ID_BITS       = 16;
    localparam int PORT_TRK_BITS = 16;

    // operation codes on the op port
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    // decisions of the shared compare unit for one list entry
    typedef struct packed {
        logic key_lt_ent;   // key track below entry track
        logic key_eq_ent;   // key track equals entry track
        logic take_left;    // entry is a closer candidate below the key
        logic take_right;   // entry is a closer candidate above the key
    } pick_flags_t;

endpackage

// File: design/elevator_disk_request_scheduler.sv
// add: walks down from the top entry, moving each larger entry up a slot, then writes
//   the request into the opened slot; an add to a full list is dropped
// take: scans up from the bottom to the first exact match or the end, chooses, moves
//   later entries down to close the gap, and presents the result (none if list empty)
// one item at a time; the list memory has one write port and one registered read port
// reset: list empty, sweep direction up, no result pending; list memory is not cleared
module elevator_disk_request_scheduler
    import edrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = EDRS_QUEUE_DEPTH,
    parameter int TRACK_BITS  = EDRS_TRACK_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     op,
    input  logic [PORT_TRK_BITS-1:0] req_track,
    input  logic [ID_BITS-1:0]       req_id,
    input  logic [PORT_TRK_BITS-1:0] head_track,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     has_request,
    output logic [ID_BITS-1:0]       out_id,
    output logic [PORT_TRK_BITS-1:0] out_track,
    output logic                     add_dropped,
    output logic                     moving_up
);

    localparam int AW       = $clog2(QUEUE_DEPTH);
    localparam int CW       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_BITS = TRACK_BITS + ID_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_PUT,
        S_SCAN,
        S_CHOOSE,
        S_REM,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [CW-1:0]           count_reg;
    logic                    dir_up_reg;
    logic [AW-1:0]           ptr_reg;

    // item held during its work
    logic [TRACK_BITS-1:0]   key_reg;
    logic [ID_BITS-1:0]      id_reg;

    // best candidates of the scan; an exact match lands in the left slot
    logic                    hit_reg;
    logic                    left_vld_reg;
    logic [TRACK_BITS-1:0]   left_trk_reg;
    logic [ID_BITS-1:0]      left_id_reg;
    logic [AW-1:0]           left_pos_reg;
    logic                    right_vld_reg;
    logic [TRACK_BITS-1:0]   right_trk_reg;
    logic [ID_BITS-1:0]      right_id_reg;
    logic [AW-1:0]           right_pos_reg;

    // result under construction
    logic                    has_reg;
    logic [ID_BITS-1:0]      res_id_reg;
    logic [TRACK_BITS-1:0]   res_trk_reg;
    logic                    drop_reg;

    // output stage
    logic                     out_valid_reg;
    logic                     has_out_reg;
    logic [ID_BITS-1:0]       id_out_reg;
    logic [PORT_TRK_BITS-1:0] trk_out_reg;
    logic                     drop_out_reg;
    logic                     up_out_reg;

    // memory port
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [ENT_BITS-1:0]     rd_data;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [ENT_BITS-1:0]     wr_data;

    logic                    in_xfer;
    logic [TRACK_BITS-1:0]   trk_in;
    logic [TRACK_BITS-1:0]   head_in;
    logic [TRACK_BITS-1:0]   ent_trk;
    logic [ID_BITS-1:0]      ent_id;
    logic [AW-1:0]           last_idx;
    logic                    at_last;
    logic                    list_full;
    pick_flags_t             flags;

    // selection made in the choose step
    logic                    use_left;
    logic [AW-1:0]           sel_pos;
    logic [ID_BITS-1:0]      sel_id;
    logic [TRACK_BITS-1:0]   sel_trk;
    logic                    sel_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;

    // tracks live in TRACK_BITS bits; wider port bits are dropped
    assign trk_in    = TRACK_BITS'(req_track);
    assign head_in   = TRACK_BITS'(head_track);

    assign ent_trk   = rd_data[ID_BITS +: TRACK_BITS];
    assign ent_id    = rd_data[ID_BITS-1:0];

    assign last_idx  = AW'(count_reg - CW'(1));
    assign at_last   = (CW'(ptr_reg) == (count_reg - CW'(1)));
    assign list_full = (count_reg == CW'(QUEUE_DEPTH));

    // exact match first, then the sweep direction, reversing if nothing lies ahead
    assign use_left  = hit_reg || (dir_up_reg ? !right_vld_reg : left_vld_reg);
    assign sel_pos   = use_left ? left_pos_reg : right_pos_reg;
    assign sel_id    = use_left ? left_id_reg  : right_id_reg;
    assign sel_trk   = use_left ? left_trk_reg : right_trk_reg;
    assign sel_last  = (CW'(sel_pos) == (count_reg - CW'(1)));

    // shared compare unit, used by the insert walk and the take scan
    edrs_pick #(
        .TRACK_BITS (TRACK_BITS)
    ) u_pick (
        .key_trk   (key_reg),
        .ent_trk   (ent_trk),
        .left_vld  (left_vld_reg),
        .left_trk  (left_trk_reg),
        .right_vld (right_vld_reg),
        .right_trk (right_trk_reg),
        .flags     (flags)
    );

    // sorted request list
    edrs_store #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENT_BITS)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // memory access per step
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = ptr_reg;
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = {key_reg, id_reg};
        unique case (state_reg)
            S_IDLE:
            begin
                // insert walks down from the top entry, take scans up from the bottom
                if (in_xfer)
                begin
                    rd_en   = 1'b1;
                    rd_addr = (op == OP_ADD) ? last_idx : '0;
                end
            end
            S_INS:
            begin
                // move the entry up one slot, or drop the new request in above it
                wr_en   = 1'b1;
                wr_addr = ptr_reg + AW'(1);
                if (flags.key_lt_ent)
                begin
                    wr_data = rd_data;
                    if (ptr_reg != '0)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = ptr_reg - AW'(1);
                    end
                end
            end
            S_INS_PUT:
            begin
                wr_en = 1'b1;
            end
            S_SCAN:
            begin
                if (!flags.key_eq_ent && !at_last)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_reg + AW'(1);
                end
            end
            S_CHOOSE:
            begin
                if (!sel_last)
                begin
                    rd_en   = 1'b1;
                    rd_addr = sel_pos + AW'(1);
                end
            end
            S_REM:
            begin
                // close the gap left by the served entry
                wr_en   = 1'b1;
                wr_addr = ptr_reg - AW'(1);
                wr_data = rd_data;
                if (!at_last)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_reg + AW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dir_up_reg    <= 1'b1;
            ptr_reg       <= '0;
            key_reg       <= '0;
            id_reg        <= '0;
            hit_reg       <= 1'b0;
            left_vld_reg  <= 1'b0;
            left_trk_reg  <= '0;
            left_id_reg   <= '0;
            left_pos_reg  <= '0;
            right_vld_reg <= 1'b0;
            right_trk_reg <= '0;
            right_id_reg  <= '0;
            right_pos_reg <= '0;
            has_reg       <= 1'b0;
            res_id_reg    <= '0;
            res_trk_reg   <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            has_out_reg   <= 1'b0;
            id_out_reg    <= '0;
            trk_out_reg   <= '0;
            drop_out_reg  <= 1'b0;
            up_out_reg    <= 1'b1;
        end
        else
        begin
            // the done step reloads the output stage itself
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        key_reg       <= (op == OP_ADD) ? trk_in : head_in;
                        id_reg        <= req_id;
                        hit_reg       <= 1'b0;
                        left_vld_reg  <= 1'b0;
                        right_vld_reg <= 1'b0;
                        has_reg       <= 1'b0;
                        res_id_reg    <= '0;
                        res_trk_reg   <= '0;
                        drop_reg      <= 1'b0;
                        if (op == OP_ADD)
                        begin
                            if (list_full)
                            begin
                                drop_reg  <= 1'b1;
                                state_reg <= S_DONE;
                            end
                            else if (count_reg == '0)
                            begin
                                ptr_reg   <= '0;
                                state_reg <= S_INS_PUT;
                            end
                            else
                            begin
                                ptr_reg   <= last_idx;
                                state_reg <= S_INS;
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            ptr_reg   <= '0;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_INS:
                begin
                    if (flags.key_lt_ent)
                    begin
                        if (ptr_reg == '0)
                        begin
                            state_reg <= S_INS_PUT;
                        end
                        else
                        begin
                            ptr_reg <= ptr_reg - AW'(1);
                        end
                    end
                    else
                    begin
                        count_reg <= count_reg + CW'(1);
                        state_reg <= S_DONE;
                    end
                end
                S_INS_PUT:
                begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_DONE;
                end
                S_SCAN:
                begin
                    if (flags.key_eq_ent)
                    begin
                        hit_reg      <= 1'b1;
                        left_trk_reg <= ent_trk;
                        left_id_reg  <= ent_id;
                        left_pos_reg <= ptr_reg;
                        state_reg    <= S_CHOOSE;
                    end
                    else
                    begin
                        if (flags.take_left)
                        begin
                            left_vld_reg <= 1'b1;
                            left_trk_reg <= ent_trk;
                            left_id_reg  <= ent_id;
                            left_pos_reg <= ptr_reg;
                        end
                        if (flags.take_right)
                        begin
                            right_vld_reg <= 1'b1;
                            right_trk_reg <= ent_trk;
                            right_id_reg  <= ent_id;
                            right_pos_reg <= ptr_reg;
                        end
                        if (at_last)
                        begin
                            state_reg <= S_CHOOSE;
                        end
                        else
                        begin
                            ptr_reg <= ptr_reg + AW'(1);
                        end
                    end
                end
                S_CHOOSE:
                begin
                    has_reg     <= 1'b1;
                    res_id_reg  <= sel_id;
                    res_trk_reg <= sel_trk;
                    // nothing ahead in the sweep: turn around
                    if (!hit_reg && dir_up_reg && !right_vld_reg)
                    begin
                        dir_up_reg <= 1'b0;
                    end
                    else if (!hit_reg && !dir_up_reg && !left_vld_reg)
                    begin
                        dir_up_reg <= 1'b1;
                    end
                    if (sel_last)
                    begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        ptr_reg   <= sel_pos + AW'(1);
                        state_reg <= S_REM;
                    end
                end
                S_REM:
                begin
                    if (at_last)
                    begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + AW'(1);
                    end
                end
                S_DONE:
                begin
                    // load the output stage once the previous result has gone
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        has_out_reg   <= has_reg;
                        id_out_reg    <= res_id_reg;
                        trk_out_reg   <= PORT_TRK_BITS'(res_trk_reg);
                        drop_out_reg  <= drop_reg;
                        up_out_reg    <= dir_up_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign has_request = has_out_reg;
    assign out_id      = id_out_reg;
    assign out_track   = trk_out_reg;
    assign add_dropped = drop_out_reg;
    assign moving_up   = up_out_reg;

    // fill count never passes the list size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("pending count above list size");

    // count moves by at most one per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CW'(1)) ||
             (count_reg == $past(count_reg) - CW'(1))))
        else $error("pending count jumped");

    // add to a full list goes straight to a dropped result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (op == OP_ADD) && list_full) |=>
            ((state_reg == S_DONE) && drop_reg && (count_reg == CW'(QUEUE_DEPTH))))
        else $error("full-list add not dropped");

    // take from an empty list reports nothing pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (op == OP_TAKE) && (count_reg == '0)) |=>
            ((state_reg == S_DONE) && !has_reg))
        else $error("empty-list take served a request");

    // scan and choose only run over a non-empty list
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) || (state_reg == S_CHOOSE)) |-> (count_reg != '0))
        else $error("scan over an empty list");

endmodule

// File: design/edrs_store.sv
module edrs_store
    import edrs_pkg::*;
#(
    parameter int DEPTH = EDRS_QUEUE_DEPTH,
    parameter int WIDTH = EDRS_TRACK_BITS + ID_BITS
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/edrs_pick.sv
module edrs_pick
    import edrs_pkg::*;
#(
    parameter int TRACK_BITS = EDRS_TRACK_BITS
)
(
    input  logic [TRACK_BITS-1:0] key_trk,
    input  logic [TRACK_BITS-1:0] ent_trk,
    input  logic                  left_vld,
    input  logic [TRACK_BITS-1:0] left_trk,
    input  logic                  right_vld,
    input  logic [TRACK_BITS-1:0] right_trk,
    output pick_flags_t           flags
);

    logic ent_lt_key;

    // list is sorted, so nearest below is the largest track below the key
    // and nearest above is the smallest track above it; strict compares
    // keep the earliest entry on a tie
    always_comb
    begin
        flags.key_lt_ent = key_trk < ent_trk;
        flags.key_eq_ent = key_trk == ent_trk;
        ent_lt_key       = !flags.key_lt_ent && !flags.key_eq_ent;
        flags.take_left  = ent_lt_key && (!left_vld || (ent_trk > left_trk));
        flags.take_right = flags.key_lt_ent && (!right_vld || (ent_trk < right_trk));
    end

endmodule
